// ===== hw/rtl/lptc_pkg.sv =====
// shared types and constants for the page tag cache
package lptc_pkg;

    // fixed field widths
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned CFG_W  = 5;
    localparam int unsigned SLOT_W = 4;

    // capacity register value after reset
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;  // capture a new item
        logic cmp;   // lookup, victim and free-entry search
        logic upd;   // write back tag, rank and occupancy changes
    } t_cmd;

endpackage

// ===== hw/rtl/lptc_ctrl.sv =====
// sequencer for the lookup and update phases of each item
module lptc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_valid,
    output lptc_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_valid;
    logic       accept;

    // a new item can enter while the previous one is in its update phase
    assign busy   = (r_state == ST_CMP);
    assign accept = start && !busy;

    // next state
    always_comb begin
        case (r_state)
            ST_IDLE: n_state = accept ? ST_CMP : ST_IDLE;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD:  n_state = accept ? ST_CMP : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_UPD);
        end
    end

    // commands
    always_comb begin
        o_cmd.load = accept;
        o_cmd.cmp  = (r_state == ST_CMP);
        o_cmd.upd  = (r_state == ST_UPD);
    end

    assign o_valid = r_valid;

endmodule

// ===== hw/rtl/lptc_dp.sv =====
// tag cells, recency ranks, occupancy and result registers
module lptc_dp #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lptc_pkg::t_cmd                    i_cmd,
    input  logic                              i_cfg_we,
    input  logic [lptc_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic [lptc_pkg::KEY_W-1:0]        i_file_number,
    input  logic [lptc_pkg::KEY_W-1:0]        i_block_number,
    input  logic                              i_mark_dirty,
    output logic                              o_error,
    output logic                              o_hit,
    output logic [lptc_pkg::SLOT_W-1:0]       o_slot,
    output logic                              o_evicted,
    output logic [lptc_pkg::KEY_W-1:0]        o_evicted_file,
    output logic [lptc_pkg::KEY_W-1:0]        o_evicted_block,
    output logic                              o_needs_writeback
);

    localparam int unsigned IDXW = $clog2(CAPACITY);
    localparam int unsigned OCCW = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (OCCW > lptc_pkg::CFG_W) ? OCCW : lptc_pkg::CFG_W;

    // entry cells
    logic [CAPACITY-1:0]          r_valid;
    logic [CAPACITY-1:0]          r_dirty;
    logic [lptc_pkg::KEY_W-1:0]   r_efile  [CAPACITY];
    logic [lptc_pkg::KEY_W-1:0]   r_eblock [CAPACITY];
    logic [IDXW-1:0]              r_rank   [CAPACITY];
    logic [OCCW-1:0]              r_occ;
    logic [lptc_pkg::CFG_W-1:0]   r_cap;

    // captured item
    logic [lptc_pkg::KEY_W-1:0]   r_file;
    logic [lptc_pkg::KEY_W-1:0]   r_block;
    logic                         r_mark;

    // lookup results
    logic                         r_err;
    logic                         r_hit;
    logic                         r_evict;
    logic [IDXW-1:0]              r_hit_idx;
    logic [IDXW-1:0]              r_hit_rank;
    logic [IDXW-1:0]              r_vict_idx;
    logic [IDXW-1:0]              r_fill_idx;

    // result registers
    logic                         r_o_error;
    logic                         r_o_hit;
    logic [lptc_pkg::SLOT_W-1:0]  r_o_slot;
    logic                         r_o_evicted;
    logic [lptc_pkg::KEY_W-1:0]   r_o_efile;
    logic [lptc_pkg::KEY_W-1:0]   r_o_eblock;
    logic                         r_o_wb;

    logic [CAPACITY-1:0]          match_vec;
    logic [CAPACITY-1:0]          vict_vec;
    logic [CAPACITY-1:0]          free_vec;
    logic                         is_err;
    logic                         any_hit;
    logic                         need_evict;
    logic                         do_evict;
    logic [IDXW-1:0]              hit_idx;
    logic [IDXW-1:0]              vict_idx;
    logic [IDXW-1:0]              fill_idx;
    logic [IDXW-1:0]              oldest_rank;
    logic [CMPW-1:0]              cfg_ext;
    logic [CMPW-1:0]              cap_max;
    logic [CMPW-1:0]              eff_cap;

    // lowest set index of a vector
    function automatic logic [IDXW-1:0] lowest(input logic [CAPACITY-1:0] v);
        logic [IDXW-1:0] idx;
        idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDXW'(i);
            end
        end
        return idx;
    endfunction

    // effective capacity: zero acts as one, large values saturate
    assign cfg_ext = CMPW'(r_cap);
    assign cap_max = CMPW'(CAPACITY);
    always_comb begin
        if (cfg_ext == '0) begin
            eff_cap = CMPW'(1);
        end else if (cfg_ext > cap_max) begin
            eff_cap = cap_max;
        end else begin
            eff_cap = cfg_ext;
        end
    end

    // per-cell compare; valid ranks run 0..occupancy-1, so the lru entry has the top rank
    assign oldest_rank = IDXW'(r_occ - OCCW'(1));
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match_vec[i] = r_valid[i] && (r_efile[i] == r_file) && (r_eblock[i] == r_block);
            vict_vec[i]  = r_valid[i] && (r_rank[i] == oldest_rank);
        end
    end

    assign is_err     = (r_block == '0);
    assign any_hit    = |match_vec;
    assign hit_idx    = lowest(match_vec);
    assign need_evict = !is_err && !any_hit && (CMPW'(r_occ) >= eff_cap);
    assign do_evict   = need_evict && (|vict_vec);
    assign vict_idx   = lowest(vict_vec);
    assign free_vec   = ~r_valid | (do_evict ? vict_vec : '0);
    assign fill_idx   = lowest(free_vec);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lptc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_file  <= i_file_number;
            r_block <= i_block_number;
            r_mark  <= i_mark_dirty;
        end
    end

    // lookup phase registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_err      <= is_err;
            r_hit      <= !is_err && any_hit;
            r_evict    <= do_evict;
            r_hit_idx  <= hit_idx;
            r_hit_rank <= r_rank[hit_idx];
            r_vict_idx <= vict_idx;
            r_fill_idx <= fill_idx;
        end
    end

    // valid, dirty and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_occ   <= '0;
        end else if (i_cmd.upd && !r_err) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (r_hit) begin
                    if (IDXW'(i) == r_hit_idx && r_mark) begin
                        r_dirty[i] <= 1'b1;
                    end
                end else if (IDXW'(i) == r_fill_idx) begin
                    r_valid[i] <= 1'b1;
                    r_dirty[i] <= r_mark;
                end else if (r_evict && IDXW'(i) == r_vict_idx) begin
                    r_valid[i] <= 1'b0;
                    r_dirty[i] <= 1'b0;
                end
            end
            if (!r_hit && !r_evict && r_occ < OCCW'(CAPACITY)) begin
                r_occ <= r_occ + OCCW'(1);
            end
        end
    end

    // tags and recency ranks
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && !r_err) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (r_hit) begin
                    if (IDXW'(i) == r_hit_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && r_rank[i] < r_hit_rank) begin
                        r_rank[i] <= r_rank[i] + IDXW'(1);
                    end
                end else if (IDXW'(i) == r_fill_idx) begin
                    r_efile[i]  <= r_file;
                    r_eblock[i] <= r_block;
                    r_rank[i]   <= '0;
                end else if (r_valid[i]) begin
                    r_rank[i] <= r_rank[i] + IDXW'(1);
                end
            end
        end
    end

    // result registers, loaded in the update phase
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_o_error   <= r_err;
            r_o_hit     <= r_hit;
            r_o_evicted <= r_evict;
            if (r_err) begin
                r_o_slot <= '0;
            end else if (r_hit) begin
                r_o_slot <= lptc_pkg::SLOT_W'(r_hit_idx);
            end else begin
                r_o_slot <= lptc_pkg::SLOT_W'(r_fill_idx);
            end
            if (r_evict) begin
                r_o_efile  <= r_efile[r_vict_idx];
                r_o_eblock <= r_eblock[r_vict_idx];
                r_o_wb     <= r_dirty[r_vict_idx];
            end else begin
                r_o_efile  <= '0;
                r_o_eblock <= '0;
                r_o_wb     <= 1'b0;
            end
        end
    end

    assign o_error           = r_o_error;
    assign o_hit             = r_o_hit;
    assign o_slot            = r_o_slot;
    assign o_evicted         = r_o_evicted;
    assign o_evicted_file    = r_o_efile;
    assign o_evicted_block   = r_o_eblock;
    assign o_needs_writeback = r_o_wb;

endmodule

// ===== hw/rtl/lru_page_tag_cache_top.sv =====
// top level of the fully associative lru page tag cache
//
// Usage:
//   Request channel: drive i_file_number, i_block_number and i_mark_dirty with
//   start high; the item is taken at a rising edge where start is high and busy
//   is low. Each item gives one result: o_valid is high for one cycle with
//   o_error, o_hit, o_slot, o_evicted, o_evicted_file, o_evicted_block and
//   o_needs_writeback. The receiver must take it in that cycle; it cannot stall.
//   Each item passes a lookup state, then an update state that registers its
//   result. busy is high for the single lookup cycle, in which all tag cells
//   compare and the victim and free entry are chosen; the next item is taken
//   in the update cycle that follows. Config: i_cfg_we with i_cfg_wdata writes
//   the capacity register; zero acts as one, values above CAPACITY saturate.
//   Only write it while no item is in flight; the block does not enforce this.
//   Reset (i_rst_n low, synchronous): the cache is empty, occupancy is zero,
//   capacity reads 16 and no result is pending; no clearing pass is needed.
module lru_page_tag_cache_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lptc_pkg::KEY_W-1:0]    i_file_number,
    input  logic [lptc_pkg::KEY_W-1:0]    i_block_number,
    input  logic                          i_mark_dirty,
    input  logic                          i_cfg_we,
    input  logic [lptc_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                          o_valid,
    output logic                          o_error,
    output logic                          o_hit,
    output logic [lptc_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_evicted,
    output logic [lptc_pkg::KEY_W-1:0]    o_evicted_file,
    output logic [lptc_pkg::KEY_W-1:0]    o_evicted_block,
    output logic                          o_needs_writeback
);

    lptc_pkg::t_cmd cmd;

    // controller
    lptc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // datapath
    lptc_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_file_number     (i_file_number),
        .i_block_number    (i_block_number),
        .i_mark_dirty      (i_mark_dirty),
        .o_error           (o_error),
        .o_hit             (o_hit),
        .o_slot            (o_slot),
        .o_evicted         (o_evicted),
        .o_evicted_file    (o_evicted_file),
        .o_evicted_block   (o_evicted_block),
        .o_needs_writeback (o_needs_writeback)
    );

    // an accepted item goes straight into its lookup cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && cmd.cmp))
        else $error("accepted item did not enter lookup");

    // lookup lasts exactly one cycle
    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (!busy && cmd.upd))
        else $error("lookup phase longer than one cycle");

    // every update cycle is followed by a result strobe
    a_valid_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.upd |=> o_valid)
        else $error("update cycle without result strobe");

    // an error result carries no hit, eviction or write-back flag
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (!o_hit && !o_evicted && !o_needs_writeback))
        else $error("error result carries other flags");

    // write-back only with an eviction, never on a hit
    a_wb_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_needs_writeback) |-> (o_evicted && !o_hit))
        else $error("write-back without eviction");

endmodule

// ===== test/lptc_result_checker.sv =====
// result checker for the page tag cache: tracks the lru tag state and compares every result
module lptc_result_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [lptc_pkg::KEY_W-1:0]  i_file_number,
    input  logic [lptc_pkg::KEY_W-1:0]  i_block_number,
    input  logic                        i_mark_dirty,
    input  logic                        i_cfg_we,
    input  logic [lptc_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_valid,
    input  logic                        i_error,
    input  logic                        i_hit,
    input  logic [lptc_pkg::SLOT_W-1:0] i_slot,
    input  logic                        i_evicted,
    input  logic [lptc_pkg::KEY_W-1:0]  i_evicted_file,
    input  logic [lptc_pkg::KEY_W-1:0]  i_evicted_block,
    input  logic                        i_needs_writeback,
    output int                          o_fail_count,
    output int                          o_outstanding,
    output int                          o_hits,
    output int                          o_evictions,
    output int                          o_writebacks
);
    import lptc_pkg::*;

    typedef struct packed {
        logic              error;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [KEY_W-1:0]  ev_file;
        logic [KEY_W-1:0]  ev_block;
        logic              writeback;
    } t_access_result;

    // shadow copy of the tag store
    logic              tag_valid [CAPACITY];
    logic [KEY_W-1:0]  tag_file  [CAPACITY];
    logic [KEY_W-1:0]  tag_block [CAPACITY];
    logic              tag_dirty [CAPACITY];
    logic [SLOT_W-1:0] tag_age   [CAPACITY];
    logic [CFG_W-1:0]  fill_count;
    logic [CFG_W-1:0]  cap_reg;

    t_access_result    awaited_results [$];

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("%s expected %h got %h", name, want, got));
        end
    endtask

    // one access against the shadow store: returns the result and updates the state
    task automatic model_access(input logic [KEY_W-1:0] f, input logic [KEY_W-1:0] b,
                                input logic d, output t_access_result r);
        int                hit_idx;
        int                victim;
        int                free_idx;
        int unsigned       eff_cap;
        logic [SLOT_W-1:0] oldest;
        logic [SLOT_W-1:0] hit_age;
        hit_idx  = -1;
        victim   = -1;
        free_idx = -1;
        oldest   = '0;
        r        = '0;
        eff_cap  = (cap_reg == '0) ? 1 : ((cap_reg > CAPACITY) ? CAPACITY : cap_reg);

        if (b == '0) begin
            // unmapped block: error, nothing changes
            r.error = 1'b1;
        end else begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (hit_idx < 0 && tag_valid[i] && tag_file[i] == f && tag_block[i] == b) begin
                    hit_idx = i;
                end
            end

            if (hit_idx >= 0) begin
                // hit: move to front, or in the dirty mark
                hit_age = tag_age[hit_idx];
                for (int i = 0; i < CAPACITY; i++) begin
                    if (tag_valid[i] && tag_age[i] < hit_age) begin
                        tag_age[i]++;
                    end
                end
                tag_age[hit_idx] = '0;
                if (d) begin
                    tag_dirty[hit_idx] = 1'b1;
                end
                r.hit  = 1'b1;
                r.slot = SLOT_W'(hit_idx);
            end else begin
                // miss at capacity: drop the oldest entry, lowest index on a tie
                if (fill_count >= eff_cap) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (tag_valid[i] && (victim < 0 || tag_age[i] > oldest)) begin
                            victim = i;
                            oldest = tag_age[i];
                        end
                    end
                    if (victim >= 0) begin
                        r.evicted   = 1'b1;
                        r.ev_file   = tag_file[victim];
                        r.ev_block  = tag_block[victim];
                        r.writeback = tag_dirty[victim];
                        tag_valid[victim] = 1'b0;
                        tag_dirty[victim] = 1'b0;
                        if (fill_count > 0) begin
                            fill_count--;
                        end
                    end
                end

                // fill the lowest free entry as most recent
                for (int i = 0; i < CAPACITY; i++) begin
                    if (free_idx < 0 && !tag_valid[i]) begin
                        free_idx = i;
                    end
                end
                if (free_idx < 0) begin
                    free_idx = 0;
                end
                for (int i = 0; i < CAPACITY; i++) begin
                    if (tag_valid[i]) begin
                        tag_age[i]++;
                    end
                end
                if (!tag_valid[free_idx] && fill_count < CAPACITY) begin
                    fill_count++;
                end
                tag_valid[free_idx] = 1'b1;
                tag_file[free_idx]  = f;
                tag_block[free_idx] = b;
                tag_dirty[free_idx] = d;
                tag_age[free_idx]   = '0;
                r.slot = SLOT_W'(free_idx);
            end
        end
    endtask

    // sample both channels on the clock edge
    always @(posedge i_clk) begin
        t_access_result seen;
        t_access_result oldest_want;
        t_access_result fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                tag_valid[i] = 1'b0;
                tag_dirty[i] = 1'b0;
                tag_file[i]  = '0;
                tag_block[i] = '0;
                tag_age[i]   = '0;
            end
            fill_count = '0;
            cap_reg    = CAP_RESET;
            awaited_results.delete();
            o_fail_count = 0;
            o_hits       = 0;
            o_evictions  = 0;
            o_writebacks = 0;
        end else begin
            // results leave first so a same-edge item cannot be matched early
            if (i_valid === 1'b1) begin
                seen = '{i_error, i_hit, i_slot, i_evicted, i_evicted_file,
                         i_evicted_block, i_needs_writeback};
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    oldest_want = awaited_results.pop_front();
                    check_field("error", oldest_want.error, seen.error);
                    check_field("hit", oldest_want.hit, seen.hit);
                    check_field("slot", oldest_want.slot, seen.slot);
                    check_field("evicted", oldest_want.evicted, seen.evicted);
                    check_field("evicted_file", oldest_want.ev_file, seen.ev_file);
                    check_field("evicted_block", oldest_want.ev_block, seen.ev_block);
                    check_field("needs_writeback", oldest_want.writeback, seen.writeback);
                    o_hits       += oldest_want.hit;
                    o_evictions  += oldest_want.evicted;
                    o_writebacks += oldest_want.writeback;
                end
            end

            if (i_cfg_we === 1'b1) begin
                cap_reg = i_cfg_wdata;
            end

            if (i_start === 1'b1 && i_busy === 1'b0) begin
                model_access(i_file_number, i_block_number, i_mark_dirty, fresh);
                awaited_results.push_back(fresh);
            end
        end
        o_outstanding <= awaited_results.size();
    end

endmodule

// ===== test/tb_lru_page_tag_cache_top.sv =====
// testbench top for the page tag cache: drives accesses and capacity writes, gives the verdict
module tb_lru_page_tag_cache_top;
    import lptc_pkg::*;

    localparam int unsigned CAPACITY    = 16;
    localparam int unsigned POOL_SIZE   = 24;
    localparam int unsigned PHASES      = 7;
    localparam int unsigned PHASE_ITEMS = 93;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              start             = 1'b0;
    logic              busy;
    logic [KEY_W-1:0]  i_file_number     = '0;
    logic [KEY_W-1:0]  i_block_number    = '0;
    logic              i_mark_dirty      = 1'b0;
    logic              i_cfg_we          = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata       = '0;
    logic              o_valid;
    logic              o_error;
    logic              o_hit;
    logic [SLOT_W-1:0] o_slot;
    logic              o_evicted;
    logic [KEY_W-1:0]  o_evicted_file;
    logic [KEY_W-1:0]  o_evicted_block;
    logic              o_needs_writeback;

    int          fail_count;
    int          outstanding;
    int          hits;
    int          evictions;
    int          writebacks;
    int unsigned cycle_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned directed_items = 0;
    int unsigned cap_writes     = 0;

    // keys that the random part revisits so hits and evictions both happen
    logic [KEY_W-1:0] pool_file  [POOL_SIZE];
    logic [KEY_W-1:0] pool_block [POOL_SIZE];

    always #10 i_clk = ~i_clk;

    lru_page_tag_cache_top #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_file_number    (i_file_number),
        .i_block_number   (i_block_number),
        .i_mark_dirty     (i_mark_dirty),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_error          (o_error),
        .o_hit            (o_hit),
        .o_slot           (o_slot),
        .o_evicted        (o_evicted),
        .o_evicted_file   (o_evicted_file),
        .o_evicted_block  (o_evicted_block),
        .o_needs_writeback(o_needs_writeback)
    );

    lptc_result_checker #(
        .CAPACITY(CAPACITY)
    ) u_result_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_file_number    (i_file_number),
        .i_block_number   (i_block_number),
        .i_mark_dirty     (i_mark_dirty),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (o_valid),
        .i_error          (o_error),
        .i_hit            (o_hit),
        .i_slot           (o_slot),
        .i_evicted        (o_evicted),
        .i_evicted_file   (o_evicted_file),
        .i_evicted_block  (o_evicted_block),
        .i_needs_writeback(o_needs_writeback),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_hits           (hits),
        .o_evictions      (evictions),
        .o_writebacks     (writebacks)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly back to back (always when quiet), sometimes a short pause, rarely a long one
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            pick_gap = 0;
        end else if (r < 90) begin
            pick_gap = $urandom_range(1, 3);
        end else begin
            pick_gap = $urandom_range(8, 40);
        end
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_access(input logic [KEY_W-1:0] f, input logic [KEY_W-1:0] b,
                               input logic d, input int unsigned gap);
        i_file_number  <= f;
        i_block_number <= b;
        i_mark_dirty   <= d;
        start          <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every result to come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    // mostly pool keys, some fully random, some unmapped, some near misses
    task automatic random_access(input int unsigned pool_lim, input bit quiet);
        int unsigned      pick;
        int unsigned      k;
        logic [KEY_W-1:0] f;
        logic [KEY_W-1:0] b;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, pool_lim - 1);
        f    = pool_file[k];
        b    = pool_block[k];
        if (pick >= 94) begin
            b = b ^ (32'd1 << $urandom_range(0, 31));
        end else if (pick >= 88) begin
            f = $urandom;
            b = '0;
        end else if (pick >= 80) begin
            f = $urandom;
            b = $urandom;
        end
        send_access(f, b, ($urandom_range(0, 3) == 0), pick_gap(quiet));
    endtask

    initial begin
        logic [CFG_W-1:0] cap_plan [PHASES];
        int unsigned      eff_cap;
        int unsigned      pool_lim;

        cap_plan    = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd12, 5'd16};
        cap_plan[6] = CFG_W'($urandom_range(0, 31));

        // key pool: corner keys first, then random ones, some sharing a file
        pool_file[0] = '0;            pool_block[0] = 32'd1;
        pool_file[1] = '1;            pool_block[1] = '1;
        pool_file[2] = '1;            pool_block[2] = 32'd1;
        pool_file[3] = '0;            pool_block[3] = '1;
        for (int i = 4; i < POOL_SIZE; i++) begin
            pool_file[i]  = (i % 3 == 0) ? pool_file[i-1] : $urandom;
            pool_block[i] = $urandom;
            if (pool_block[i] == '0) begin
                pool_block[i] = 32'd1;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unmapped blocks, then fills and hits at the key extremes
        send_access('0, '0, 1'b0, 0);
        send_access('1, '0, 1'b1, 1);
        send_access('0, 32'd1, 1'b0, 0);
        send_access('1, '1, 1'b1, 0);
        send_access('0, 32'd1, 1'b1, 2);
        send_access('1, '1, 1'b0, 0);
        send_access('0, '1, 1'b0, 0);
        send_access('1, 32'd1, 1'b0, 0);

        // capacity lowered below occupancy: each miss evicts one entry
        drain();
        write_capacity(5'd2);
        send_access(32'd2, 32'd2, 1'b0, 0);
        send_access(32'd3, 32'd3, 1'b1, 1);
        send_access(32'd2, 32'd2, 1'b1, 0);

        // zero capacity acts as one
        drain();
        write_capacity(5'd0);
        send_access(32'd4, 32'd4, 1'b0, 0);
        send_access(32'd5, 32'd5, 1'b0, 0);

        // capacity above the array size saturates
        drain();
        write_capacity(5'd31);
        send_access(32'd6, 32'd6, 1'b0, 0);
        send_access(32'd7, 32'd7, 1'b1, 0);
        send_access(32'd6, 32'd6, 1'b0, 0);
        directed_items = items_sent;

        // random phases, one capacity setting each, drained in between
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_capacity(cap_plan[p]);
            eff_cap  = (cap_plan[p] == '0) ? 1
                     : ((cap_plan[p] > CAPACITY) ? CAPACITY : cap_plan[p]);
            pool_lim = eff_cap + $urandom_range(1, 8);
            if (pool_lim > POOL_SIZE) begin
                pool_lim = POOL_SIZE;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_access(pool_lim, p == 5);
            end
        end

        drain();
        repeat (5) @(posedge i_clk);

        $display("sent %0d items (%0d directed) across %0d capacity writes",
                 items_sent, directed_items, cap_writes);
        $display("results seen: %0d hits, %0d evictions, %0d of them dirty",
                 hits, evictions, writebacks);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== lru_page_tag_cache_top.f =====
hw/rtl/lptc_pkg.sv
hw/rtl/lptc_ctrl.sv
hw/rtl/lptc_dp.sv
hw/rtl/lru_page_tag_cache_top.sv
test/lptc_result_checker.sv
test/tb_lru_page_tag_cache_top.sv
